@@ rtl/column_floor_edge_scan_top_macros.svh @@
// ---------------------------------------------------------------------------
// Column floor edge scan assertion macros
// Shared shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef COLUMN_FLOOR_EDGE_SCAN_TOP_MACROS_SVH
`define COLUMN_FLOOR_EDGE_SCAN_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFES_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cfes_pkg.sv @@
// ---------------------------------------------------------------------------
// Column floor edge scan package
// Field widths, opcodes, register indexes and the per-column entry type.
// ---------------------------------------------------------------------------
package cfes_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned OP_W     = 2;
   localparam int unsigned COL_W    = 7;
   localparam int unsigned ROW_W    = 10;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned THR_W    = 8;
   localparam int unsigned CSR_IDX_W = 1;

   // Default number of column groups held in the column memory.
   localparam int unsigned COLUMNS_DEF = 128;

   // Rows at or above this limit never update a column.
   localparam int unsigned MAX_ROWS = 1024;
   localparam int unsigned ROW_CMP_W = 17;

   // Threshold values after reset.
   localparam logic [THR_W-1:0] LUMA_THR_RST   = 8'd30;
   localparam logic [THR_W-1:0] CHROMA_THR_RST = 8'd5;

   // Item opcodes.
   typedef enum logic [OP_W-1:0] {
      OP_LUMA_SEED   = 2'd0,
      OP_LUMA_CMP    = 2'd1,
      OP_CHROMA_SEED = 2'd2,
      OP_CHROMA_CMP  = 2'd3
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA_THR   = 1'b0,
      CSR_CHROMA_THR = 1'b1
   } csr_index_type;

   // One column entry: running average and recorded edge row.
   typedef struct packed {
      logic [PIX_W-1:0] avg;
      logic [ROW_W-1:0] edge_row;
   } entry_type;

endpackage

@@ rtl/column_floor_edge_scan_top.sv @@
// ---------------------------------------------------------------------------
// Column floor edge scan
// Tracks a running average per 8-pixel column and records the row at which
// a pixel group first strays from it by more than the plane's threshold.
// ---------------------------------------------------------------------------
//   Channel  Ports                                          Direction
//   req      req_valid/ready, opcode, column, row, pixels   in
//   rsp      rsp_valid/ready, column_out, floor_row, hit    out
//   csr      csr_valid/ready, csr_index, csr_wdata          in
//
// One item per cycle unless a result stalls; a beat passes the item stage,
// then the result register that offers it. The column memory is read at the
// accept edge and written back when the item moves to the result register;
// a one-entry bypass covers a following item on the same column. Reset loads
// the reset thresholds and clears the edge-row valid bits, with no clearing
// pass. A stalled result holds the item stage, and req_ready drops only while
// both the item stage and the result are full and the result is not taken.
// ---------------------------------------------------------------------------
module column_floor_edge_scan_top #(
   parameter int unsigned COLUMNS = cfes_pkg::COLUMNS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cfes_pkg::OP_W-1:0]     req_opcode,
   input  logic [cfes_pkg::COL_W-1:0]    req_column,
   input  logic [cfes_pkg::ROW_W-1:0]    req_row_level,
   input  logic [cfes_pkg::WORD_W-1:0]   req_pixel_lo,
   input  logic [cfes_pkg::WORD_W-1:0]   req_pixel_hi,
   // Results
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cfes_pkg::COL_W-1:0]    rsp_column_out,
   output logic [cfes_pkg::ROW_W-1:0]    rsp_floor_row,
   output logic                          rsp_edge_hit,
   // Configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfes_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cfes_pkg::THR_W-1:0]    csr_wdata
);

`include "column_floor_edge_scan_top_macros.svh"

   localparam int unsigned ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int unsigned CMP_W  =
      (ADDR_W + 1 > cfes_pkg::COL_W) ? ADDR_W + 1 : cfes_pkg::COL_W;
   localparam int unsigned PIX_W  = cfes_pkg::PIX_W;
   localparam int unsigned ROW_W  = cfes_pkg::ROW_W;

   // Thresholds.
   logic [cfes_pkg::THR_W-1:0] luma_thr_ff, luma_thr_in;
   logic [cfes_pkg::THR_W-1:0] chroma_thr_ff, chroma_thr_in;

   // Item stage.
   logic                   s1_vld_ff, s1_vld_in;
   cfes_pkg::opcode_type   s1_op_ff, s1_op_in;
   logic [cfes_pkg::COL_W-1:0] s1_col_ff, s1_col_in;
   logic                   s1_col_ok_ff, s1_col_ok_in;
   logic [ADDR_W-1:0]      s1_addr_ff, s1_addr_in;
   logic [ROW_W-1:0]       s1_row_ff, s1_row_in;
   logic [PIX_W-1:0]       s1_mean_ff, s1_mean_in;
   cfes_pkg::entry_type    rd_entry_ff;
   logic                   rd_edge_vld_ff;

   // Last write, for the bypass.
   logic                   wr_vld_ff, wr_vld_in;
   logic [ADDR_W-1:0]      wr_addr_ff, wr_addr_in;
   cfes_pkg::entry_type    wr_entry_ff, wr_entry_in;

   // Column memory and edge-row valid bits.
   cfes_pkg::entry_type    col_mem [COLUMNS];
   logic [COLUMNS-1:0]     edge_vld_ff, edge_vld_in;

   // Result register.
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [cfes_pkg::COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic                   rsp_hit_ff, rsp_hit_in;

   // Handshake terms.
   logic req_fire;
   logic s1_adv;
   logic mem_wr;

   // Front-end terms.
   logic [ADDR_W-1:0]       req_addr;
   logic [9:0]              sum_lo;
   logic [9:0]              sum_hi;
   logic [10:0]             sum_all;
   cfes_pkg::opcode_type    req_op;

   // Item stage datapath.
   cfes_pkg::entry_type     cur_entry;
   logic                    is_chroma;
   logic                    is_cmp;
   logic                    row_active;
   logic signed [PIX_W:0]   diff;
   logic [PIX_W:0]          mag;
   logic [PIX_W:0]          step_mag;
   logic signed [PIX_W:0]   step;
   logic signed [PIX_W:0]   avg_sum;
   logic [cfes_pkg::THR_W-1:0] thr;
   logic                    hit;
   cfes_pkg::entry_type     new_entry;

   // Handshake.
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign mem_wr    = s1_adv && s1_col_ok_ff;

   // Group mean and column address for the incoming beat.
   always_comb begin
      req_op   = cfes_pkg::opcode_type'(req_opcode);
      req_addr = ADDR_W'(req_column);
      sum_lo   = 10'(req_pixel_lo[7:0]) + 10'(req_pixel_lo[15:8])
               + 10'(req_pixel_lo[23:16]) + 10'(req_pixel_lo[31:24]);
      sum_hi   = 10'(req_pixel_hi[7:0]) + 10'(req_pixel_hi[15:8])
               + 10'(req_pixel_hi[23:16]) + 10'(req_pixel_hi[31:24]);
      sum_all  = 11'(sum_lo) + 11'(sum_hi);
   end

   // Configuration writes.
   always_comb begin
      luma_thr_in   = luma_thr_ff;
      chroma_thr_in = chroma_thr_ff;
      if (csr_valid) begin
         case (cfes_pkg::csr_index_type'(csr_index))
            cfes_pkg::CSR_LUMA_THR:   luma_thr_in   = csr_wdata;
            cfes_pkg::CSR_CHROMA_THR: chroma_thr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Item stage next values.
   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_op_in     = s1_op_ff;
      s1_col_in    = s1_col_ff;
      s1_col_ok_in = s1_col_ok_ff;
      s1_addr_in   = s1_addr_ff;
      s1_row_in    = s1_row_ff;
      s1_mean_in   = s1_mean_ff;
      if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      if (req_fire) begin
         s1_vld_in    = 1'b1;
         s1_op_in     = req_op;
         s1_col_in    = req_column;
         s1_col_ok_in = CMP_W'(req_column) < CMP_W'(COLUMNS);
         s1_addr_in   = req_addr;
         s1_row_in    = req_row_level;
         case (req_op)
            cfes_pkg::OP_CHROMA_SEED,
            cfes_pkg::OP_CHROMA_CMP: s1_mean_in = sum_lo[9:2];
            default:                 s1_mean_in = sum_all[10:3];
         endcase
      end
   end

   // Current entry, taking the previous write when it hit the same column.
   always_comb begin
      if (wr_vld_ff && wr_addr_ff == s1_addr_ff) begin
         cur_entry = wr_entry_ff;
      end else begin
         cur_entry.avg      = rd_entry_ff.avg;
         cur_entry.edge_row = rd_edge_vld_ff ? rd_entry_ff.edge_row : '0;
      end
   end

   // Deviation test and average update.
   always_comb begin
      is_chroma  = (s1_op_ff == cfes_pkg::OP_CHROMA_SEED)
                || (s1_op_ff == cfes_pkg::OP_CHROMA_CMP);
      is_cmp     = (s1_op_ff == cfes_pkg::OP_LUMA_CMP)
                || (s1_op_ff == cfes_pkg::OP_CHROMA_CMP);
      row_active = (cur_entry.edge_row <= s1_row_ff)
                && (cfes_pkg::ROW_CMP_W'(s1_row_ff)
                    < cfes_pkg::ROW_CMP_W'(cfes_pkg::MAX_ROWS));
      diff       = $signed({1'b0, s1_mean_ff}) - $signed({1'b0, cur_entry.avg});
      mag        = diff[PIX_W] ? (PIX_W+1)'(-diff) : diff;
      // Quarter of the deviation, truncated toward zero.
      step_mag   = mag >> 2;
      step       = diff[PIX_W] ? -$signed(step_mag) : $signed(step_mag);
      avg_sum    = $signed({1'b0, cur_entry.avg}) + step;
      thr        = is_chroma ? chroma_thr_ff : luma_thr_ff;
      hit        = is_cmp && row_active && (mag > (PIX_W+1)'(thr));

      new_entry = cur_entry;
      if (!is_cmp) begin
         new_entry.avg = s1_mean_ff;
         if (!is_chroma) begin
            new_entry.edge_row = '0;
         end
      end else if (row_active) begin
         new_entry.avg = avg_sum[PIX_W-1:0];
         if (hit) begin
            new_entry.edge_row = s1_row_ff;
         end
      end
   end

   // Bypass register and valid bits.
   always_comb begin
      wr_vld_in   = wr_vld_ff;
      wr_addr_in  = wr_addr_ff;
      wr_entry_in = wr_entry_ff;
      edge_vld_in = edge_vld_ff;
      if (mem_wr) begin
         wr_vld_in   = 1'b1;
         wr_addr_in  = s1_addr_ff;
         wr_entry_in = new_entry;
         edge_vld_in[s1_addr_ff] = 1'b1;
      end
   end

   // Result register next values.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;
      rsp_hit_in = rsp_hit_ff;
      if (rsp_vld_ff && rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
         rsp_col_in = s1_col_ff;
         rsp_row_in = s1_col_ok_ff ? new_entry.edge_row : '0;
         rsp_hit_in = s1_col_ok_ff && hit;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         luma_thr_ff   <= cfes_pkg::LUMA_THR_RST;
         chroma_thr_ff <= cfes_pkg::CHROMA_THR_RST;
         s1_vld_ff     <= 1'b0;
         wr_vld_ff     <= 1'b0;
         edge_vld_ff   <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         luma_thr_ff   <= luma_thr_in;
         chroma_thr_ff <= chroma_thr_in;
         s1_vld_ff     <= s1_vld_in;
         wr_vld_ff     <= wr_vld_in;
         edge_vld_ff   <= edge_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_col_ff    <= s1_col_in;
      s1_col_ok_ff <= s1_col_ok_in;
      s1_addr_ff   <= s1_addr_in;
      s1_row_ff    <= s1_row_in;
      s1_mean_ff   <= s1_mean_in;
      wr_addr_ff   <= wr_addr_in;
      wr_entry_ff  <= wr_entry_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // Column memory: registered read at the accept edge, write on retire.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         col_mem[s1_addr_ff] <= new_entry;
      end
      if (req_fire) begin
         rd_entry_ff    <= col_mem[req_addr];
         rd_edge_vld_ff <= edge_vld_ff[req_addr];
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_column_out = rsp_col_ff;
   assign rsp_floor_row  = rsp_row_ff;
   assign rsp_edge_hit   = rsp_hit_ff;

   // Checks.
   `CFES_ASSERT_NEXT(a_beat_loads_stage, clock, reset, req_fire, s1_vld_ff, "beat lost")
   `CFES_ASSERT_NOW(a_full_stalls_req, clock, reset,
      s1_vld_ff && rsp_vld_ff && !rsp_ready, !req_ready, "stage overrun")
   `CFES_ASSERT_NEXT(a_write_bypass, clock, reset, mem_wr,
      wr_vld_ff && edge_vld_ff[wr_addr_ff], "bypass not loaded")

endmodule

@@ tb/column_floor_edge_scan_top_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column floor edge scan testbench
// Drives a directed table and then random per-column scans (luma seed and
// compares, then two chroma planes) under several threshold settings, with
// random idle bursts on both channels and one long result hold-off. Every
// result beat is checked field by field against a typed row or the column model.
// ---------------------------------------------------------------------------
module column_floor_edge_scan_top_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 400;
   localparam int BLOCK_ITEMS  = 250;

   typedef struct {
      cfes_pkg::opcode_type              op;
      logic [cfes_pkg::COL_W-1:0]        col;
      logic [cfes_pkg::ROW_W-1:0]        row;
      logic [cfes_pkg::WORD_W-1:0]       lo;
      logic [cfes_pkg::WORD_W-1:0]       hi;
   } scan_item_type;

   typedef struct {
      logic [cfes_pkg::COL_W-1:0] col;
      logic [cfes_pkg::ROW_W-1:0] floor;
      logic                       hit;
   } floor_report_type;

   typedef struct {
      scan_item_type    item;
      bit               typed;
      floor_report_type report;
   } stim_row_type;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   // Block ports, all driven to known values from time zero.
   logic                           req_valid     = 1'b0;
   logic                           req_ready;
   logic [cfes_pkg::OP_W-1:0]      req_opcode    = '0;
   logic [cfes_pkg::COL_W-1:0]     req_column    = '0;
   logic [cfes_pkg::ROW_W-1:0]     req_row_level = '0;
   logic [cfes_pkg::WORD_W-1:0]    req_pixel_lo  = '0;
   logic [cfes_pkg::WORD_W-1:0]    req_pixel_hi  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready     = 1'b0;
   logic [cfes_pkg::COL_W-1:0]     rsp_column_out;
   logic [cfes_pkg::ROW_W-1:0]     rsp_floor_row;
   logic                           rsp_edge_hit;
   logic                           csr_valid     = 1'b0;
   logic                           csr_ready;
   logic [cfes_pkg::CSR_IDX_W-1:0] csr_index     = '0;
   logic [cfes_pkg::THR_W-1:0]     csr_wdata     = '0;

   column_floor_edge_scan_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_column     (req_column),
      .req_row_level  (req_row_level),
      .req_pixel_lo   (req_pixel_lo),
      .req_pixel_hi   (req_pixel_hi),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_column_out (rsp_column_out),
      .rsp_floor_row  (rsp_floor_row),
      .rsp_edge_hit   (rsp_edge_hit),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Column model state and thresholds.
   logic [cfes_pkg::PIX_W-1:0] column_avg    [cfes_pkg::COLUMNS_DEF];
   logic [cfes_pkg::ROW_W-1:0] column_edge   [cfes_pkg::COLUMNS_DEF];
   bit                         column_seeded [cfes_pkg::COLUMNS_DEF];
   logic [cfes_pkg::THR_W-1:0] luma_limit   = cfes_pkg::LUMA_THR_RST;
   logic [cfes_pkg::THR_W-1:0] chroma_limit = cfes_pkg::CHROMA_THR_RST;

   floor_report_type floor_report_q[$];
   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  quiet_run      = 1'b0;
   bit  hold_request   = 1'b0;

   // Sum of the four bytes of one pixel word.
   function automatic logic [10:0] word_byte_total(logic [cfes_pkg::WORD_W-1:0] w);
      return 11'(w[7:0]) + 11'(w[15:8]) + 11'(w[23:16]) + 11'(w[31:24]);
   endfunction

   // Advances the column model by one item and returns the result it gives.
   function automatic floor_report_type advance_floor_scan(scan_item_type it);
      logic [10:0]      total;
      logic [7:0]       mean;
      int               diff;
      int               mag;
      int               limit;
      bit               chroma;
      bit               compare;
      floor_report_type r;
      chroma  = (it.op == cfes_pkg::OP_CHROMA_SEED) || (it.op == cfes_pkg::OP_CHROMA_CMP);
      compare = (it.op == cfes_pkg::OP_LUMA_CMP) || (it.op == cfes_pkg::OP_CHROMA_CMP);
      r.col   = it.col;
      r.hit   = 1'b0;
      total   = word_byte_total(it.lo);
      if (chroma) begin
         mean = 8'(total >> 2);
      end else begin
         total = total + word_byte_total(it.hi);
         mean  = 8'(total >> 3);
      end
      if (!compare) begin
         column_avg[it.col] = mean;
         if (!chroma) begin
            column_edge[it.col] = '0;
         end
      end else if (column_edge[it.col] <= it.row) begin
         diff  = int'(mean) - int'(column_avg[it.col]);
         mag   = (diff < 0) ? -diff : diff;
         limit = chroma ? int'(chroma_limit) : int'(luma_limit);
         if (mag > limit) begin
            column_edge[it.col] = it.row;
            r.hit = 1'b1;
         end
         // Integer division truncates toward zero, as the block does.
         column_avg[it.col] = 8'(int'(column_avg[it.col]) + diff / 4);
      end
      r.floor = column_edge[it.col];
      return r;
   endfunction

   // Offers one item, waits for its beat and records what it should give.
   task automatic offer_item(scan_item_type it, bit typed, floor_report_type typed_report);
      floor_report_type predicted;
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= it.op;
      req_column    <= it.col;
      req_row_level <= it.row;
      req_pixel_lo  <= it.lo;
      req_pixel_hi  <= it.hi;
      do @(posedge clock); while (!req_ready);
      if (it.op == cfes_pkg::OP_LUMA_SEED || it.op == cfes_pkg::OP_CHROMA_SEED) begin
         column_seeded[it.col] = 1'b1;
      end
      predicted = advance_floor_scan(it);
      floor_report_q.push_back(typed ? typed_report : predicted);
   endtask

   // Lowers the item valid and waits until every result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (floor_report_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one threshold register; the block is idle here.
   task automatic write_threshold(cfes_pkg::csr_index_type idx,
                                  logic [cfes_pkg::THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == cfes_pkg::CSR_LUMA_THR) begin
         luma_limit = value;
      end else begin
         chroma_limit = value;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Four bytes scattered around a base value, clamped to a byte.
   function automatic logic [cfes_pkg::WORD_W-1:0] pixel_word_near(int base, int spread);
      logic [cfes_pkg::WORD_W-1:0] w;
      int                          v;
      for (int b = 0; b < 4; b++) begin
         v = base + int'($urandom_range(0, 2 * spread)) - spread;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         w[8*b +: 8] = 8'(v);
      end
      return w;
   endfunction

   // One column scanned bottom up: luma plane, then two chroma planes.
   task automatic scan_one_column(ref int sent);
      scan_item_type    it;
      floor_report_type none;
      int               start;
      int               step;
      int               rows;
      int               base;
      int               spread;
      int               r;
      none     = '{default: '0};
      it.col   = cfes_pkg::COL_W'($urandom_range(0, cfes_pkg::COLUMNS_DEF - 1));
      start    = $urandom_range(0, cfes_pkg::MAX_ROWS - 1);
      step     = $urandom_range(1, 40);
      rows     = $urandom_range(2, 8);
      for (int plane = 0; plane < 3; plane++) begin
         base   = $urandom_range(0, 255);
         spread = (plane == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
         for (int k = 0; k <= rows; k++) begin
            r = start - k * step;
            if (r < 0) r = 0;
            // Now and then the content jumps so that an edge shows up.
            if (k > 0 && $urandom_range(0, 4) == 0) begin
               base = $urandom_range(0, 255);
            end
            if (plane == 0) begin
               it.op = (k == 0) ? cfes_pkg::OP_LUMA_SEED : cfes_pkg::OP_LUMA_CMP;
               it.hi = pixel_word_near(base, spread);
            end else begin
               it.op = (k == 0) ? cfes_pkg::OP_CHROMA_SEED : cfes_pkg::OP_CHROMA_CMP;
               it.hi = $urandom;
            end
            it.row = cfes_pkg::ROW_W'(r);
            it.lo  = pixel_word_near(base, spread);
            offer_item(it, 1'b0, none);
            sent++;
         end
      end
   endtask

   // Random block: mostly well-formed column scans, the rest loose items.
   task automatic run_random_block(int count);
      scan_item_type    it;
      floor_report_type none;
      int               sent;
      none = '{default: '0};
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            scan_one_column(sent);
         end else begin
            it.op  = cfes_pkg::opcode_type'(cfes_pkg::OP_W'($urandom_range(0, 3)));
            it.col = cfes_pkg::COL_W'($urandom_range(0, cfes_pkg::COLUMNS_DEF - 1));
            it.row = cfes_pkg::ROW_W'($urandom);
            it.lo  = $urandom;
            it.hi  = $urandom;
            // A compare on a column with no average yet is turned into a seed.
            if (!column_seeded[it.col] && (it.op == cfes_pkg::OP_LUMA_CMP ||
                                           it.op == cfes_pkg::OP_CHROMA_CMP)) begin
               it.op = (it.op == cfes_pkg::OP_LUMA_CMP) ? cfes_pkg::OP_LUMA_SEED
                                                         : cfes_pkg::OP_CHROMA_SEED;
            end
            offer_item(it, 1'b0, none);
            sent++;
         end
      end
   endtask

   // Result side: random ready bursts, one long hold-off on request.
   initial begin
      int hold_cycles;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready   <= 1'b0;
            hold_cycles  = 0;
            while (hold_cycles < HOLD_CYCLES) begin
               @(posedge clock);
               hold_cycles++;
            end
            hold_request = 1'b0;
         end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Checks each result beat against the oldest expectation.
   always @(posedge clock) begin
      floor_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (floor_report_q.size() == 0) begin
            $display("%0t: unexpected result col %0d floor %0d hit %0d",
                     $realtime, rsp_column_out, rsp_floor_row, rsp_edge_hit);
            mismatch_count++;
         end else begin
            want = floor_report_q.pop_front();
            if (rsp_column_out !== want.col || rsp_floor_row !== want.floor ||
                rsp_edge_hit !== want.hit) begin
               $display("%0t: expected col %0d floor %0d hit %0d, got col %0d floor %0d hit %0d",
                        $realtime, want.col, want.floor, want.hit,
                        rsp_column_out, rsp_floor_row, rsp_edge_hit);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Directed rows, run with the reset thresholds (luma 30, chroma 5).
   stim_row_type directed_rows[] = '{
      // Luma seed of the brightest group clears the edge row.
      '{'{cfes_pkg::OP_LUMA_SEED,   7'd0,   10'd1023, 32'hffffffff, 32'hffffffff},
        1, '{7'd0,   10'd0,    1'b0}},
      // Darkest group against a white average is an edge at the bottom row.
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd0,   10'd1023, 32'h00000000, 32'h00000000},
        1, '{7'd0,   10'd1023, 1'b1}},
      // Row above the recorded edge leaves the column alone.
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd0,   10'd1022, 32'h00000000, 32'h00000000},
        1, '{7'd0,   10'd1023, 1'b0}},
      // Chroma seed keeps the luma edge row.
      '{'{cfes_pkg::OP_CHROMA_SEED, 7'd0,   10'd0,    32'h80808080, 32'hffffffff},
        1, '{7'd0,   10'd1023, 1'b0}},
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd0,   10'd1023, 32'h80808080, 32'h00000000},
        1, '{7'd0,   10'd1023, 1'b0}},
      // Deviation equal to the threshold is not an edge.
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd0,   10'd1023, 32'h85858585, 32'h00000000},
        0, '{default: '0}},
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd0,   10'd1023, 32'h00000000, 32'hffffffff},
        0, '{default: '0}},
      '{'{cfes_pkg::OP_LUMA_SEED,   7'd0,   10'd512,  32'h40404040, 32'h40404040},
        1, '{7'd0,   10'd0,    1'b0}},
      '{'{cfes_pkg::OP_LUMA_SEED,   7'd127, 10'd0,    32'h00000000, 32'h00000000},
        1, '{7'd127, 10'd0,    1'b0}},
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd127, 10'd0,    32'h00000000, 32'h00000000},
        1, '{7'd127, 10'd0,    1'b0}},
      // One above the luma threshold at row zero.
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd127, 10'd0,    32'h1f1f1f1f, 32'h1f1f1f1f},
        0, '{default: '0}},
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd127, 10'd1,    32'h1e1e1e1e, 32'h1e1e1e1e},
        0, '{default: '0}},
      // Flooring of the group mean over mixed bytes.
      '{'{cfes_pkg::OP_LUMA_SEED,   7'd64,  10'd700,  32'h01020304, 32'h05060708},
        0, '{default: '0}},
      // Small negative deviation truncates toward zero.
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd64,  10'd600,  32'h01010101, 32'h01010101},
        0, '{default: '0}},
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd64,  10'd599,  32'hff00ff00, 32'h00ff00ff},
        0, '{default: '0}},
      // Chroma compare on an average left by luma items.
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd64,  10'd1023, 32'haa55aa55, 32'h12345678},
        0, '{default: '0}},
      // Chroma ignores the upper pixel word.
      '{'{cfes_pkg::OP_CHROMA_SEED, 7'd1,   10'd300,  32'h10101010, 32'hffffffff},
        1, '{7'd1,   10'd0,    1'b0}},
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd1,   10'd700,  32'h10101010, 32'h00000000},
        1, '{7'd1,   10'd0,    1'b0}},
      '{'{cfes_pkg::OP_CHROMA_CMP,  7'd1,   10'd699,  32'hfefefefe, 32'h55555555},
        0, '{default: '0}},
      '{'{cfes_pkg::OP_LUMA_CMP,    7'd1,   10'd800,  32'h0f0f0f0f, 32'hf0f0f0f0},
        0, '{default: '0}}
   };

   // Threshold settings of the random phases, extremes first.
   logic [cfes_pkg::THR_W-1:0] phase_luma   [6];
   logic [cfes_pkg::THR_W-1:0] phase_chroma [6];

   // Main sequence.
   initial begin
      phase_luma   = '{8'd0, 8'd255, 8'd30, 8'd0, 8'd0, 8'd0};
      phase_chroma = '{8'd0, 8'd255, 8'd5,  8'd0, 8'd0, 8'd0};
      for (int p = 3; p < 6; p++) begin
         phase_luma[p]   = cfes_pkg::THR_W'($urandom_range(0, 60));
         phase_chroma[p] = cfes_pkg::THR_W'($urandom_range(0, 12));
      end
      for (int c = 0; c < cfes_pkg::COLUMNS_DEF; c++) begin
         column_edge[c]   = '0;
         column_avg[c]    = '0;
         column_seeded[c] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].report);
      end
      drain_results();

      for (int p = 0; p < 6; p++) begin
         write_threshold(cfes_pkg::CSR_LUMA_THR, phase_luma[p]);
         write_threshold(cfes_pkg::CSR_CHROMA_THR, phase_chroma[p]);
         // The last phase runs with no idling on either side.
         if (p == 5) begin
            quiet_run = 1'b1;
         end
         // Hold results off for a long stretch while items keep coming.
         if (p == 2) begin
            hold_request = 1'b1;
         end
         run_random_block(BLOCK_ITEMS);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && floor_report_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
